// ----- src/sorted_list_insert_engine_defines.svh -----
// Assertion macros for the sorted list insert engine checker.
`ifndef SORTED_LIST_INSERT_ENGINE_DEFINES_SVH
`define SORTED_LIST_INSERT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/slie_pkg.sv -----
// Shared constants, codes and types of the sorted list insert engine.
`timescale 1ns / 1ps

package slie_pkg;

  localparam int DEPTH = 32;
  localparam int VAL_W = 31;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SORTED = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_ENTRY    = 2'd3;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic             ins;        // place new_value this cycle
    logic             sorted;     // ordered insert (else tail append)
    logic             rot;        // rotate list left by one entry
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] head_value; // wraps into last valid cell on rot
  } slie_cmd_t;

endpackage

// ----- src/slie_cell.sv -----
// One list cell: holds an entry, shifts right on insert, left on read rotation.
`timescale 1ns / 1ps

module slie_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  slie_pkg::slie_cmd_t       cmd,
  input  logic                      left_take,
  input  logic                      left_valid,
  input  logic [slie_pkg::VAL_W-1:0] left_value,
  input  logic                      right_valid,
  input  logic [slie_pkg::VAL_W-1:0] right_value,
  output logic                      take_out,
  output logic                      valid_out,
  output logic [slie_pkg::VAL_W-1:0] value_out
);

  logic                       valid_r, valid_nxt;
  logic [slie_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                       hit;
  logic                       place;

  // Hit: first entry not smaller than the new one (prefix via left_take).
  assign hit      = cmd.sorted & valid_r & (value_r >= cmd.new_value);
  // Place: first empty cell, i.e. the tail position.
  assign place    = ~valid_r & left_valid;
  assign take_out = left_take | hit | place;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.ins) begin
      // Shift only a real entry in from the left; cells past the new tail stay empty.
      if (left_take && left_valid) begin
        valid_nxt = 1'b1;
        value_nxt = left_value;
      end else if (hit | place) begin
        valid_nxt = 1'b1;
        value_nxt = cmd.new_value;
      end
    end else if (cmd.rot && valid_r) begin
      value_nxt = right_valid ? right_value : cmd.head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign valid_out = valid_r;
  assign value_out = value_r;

endmodule

// ----- src/slie_array.sv -----
// Row of DEPTH list cells chained left to right.
`timescale 1ns / 1ps

module slie_array (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slie_pkg::slie_cmd_t        cmd,
  output logic [slie_pkg::VAL_W-1:0] head_value
);

  logic [slie_pkg::DEPTH-1:0] take;
  logic [slie_pkg::DEPTH-1:0] valid;
  logic [slie_pkg::VAL_W-1:0] value [slie_pkg::DEPTH];

  for (genvar i = 0; i < slie_pkg::DEPTH; i++) begin : g_cell
    logic                       l_take;
    logic                       l_valid;
    logic [slie_pkg::VAL_W-1:0] l_value;
    logic                       r_valid;
    logic [slie_pkg::VAL_W-1:0] r_value;

    if (i == 0) begin : g_first
      assign l_take  = 1'b0;
      assign l_valid = 1'b1;
      assign l_value = '0;
    end else begin : g_mid_l
      assign l_take  = take[i-1];
      assign l_valid = valid[i-1];
      assign l_value = value[i-1];
    end

    if (i == slie_pkg::DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = '0;
    end else begin : g_mid_r
      assign r_valid = valid[i+1];
      assign r_value = value[i+1];
    end

    slie_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_take   (l_take),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_value (r_value),
      .take_out    (take[i]),
      .valid_out   (valid[i]),
      .value_out   (value[i])
    );
  end

  assign head_value = value[0];

endmodule

// ----- src/sorted_list_insert_engine.sv -----
// Top level: command decode, entry count, read-out sequencer around the cell row.
// Append/insert answers in the cycle after accept; one command per cycle, busy stays low.
// Read-out of N entries: busy until the final word, one entry word per cycle; first word
// via busy_r and the result word register. Empty read answers in the cycle after accept.
// Read length: the entry count; row rotates left one entry per cycle. Results cannot be stalled.
// Reset (rst_n low, synchronous): list empty, busy low, no result strobe.
`timescale 1ns / 1ps

module sorted_list_insert_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [slie_pkg::VAL_W-1:0] in_new_value,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [slie_pkg::VAL_W-1:0] out_entry_value,
  output logic                       out_last
);

  // Control state
  logic                       busy_r, busy_nxt;
  logic [slie_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [slie_pkg::IDX_W-1:0] idx_r, idx_nxt;

  // Result word register
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [slie_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       accept;
  logic                       full;
  logic                       is_write;
  logic                       read_last;
  logic [slie_pkg::VAL_W-1:0] head_value;
  slie_pkg::slie_cmd_t        cmd;

  assign accept    = start & ~busy_r;
  assign full      = (count_r == slie_pkg::CNT_W'(slie_pkg::DEPTH));
  assign is_write  = (in_opcode == slie_pkg::OP_APPEND) || (in_opcode == slie_pkg::OP_SORTED);
  // Current head is the final entry when idx reaches count - 1.
  assign read_last = (slie_pkg::CNT_W'(idx_r) == count_r - slie_pkg::CNT_W'(1));

  // Broadcast to the cells. Insert position resolves in the row itself:
  // the first cell that hits (or the tail) takes new_value, later cells shift right.
  always_comb begin
    cmd.ins        = accept & is_write & ~full;
    cmd.sorted     = (in_opcode == slie_pkg::OP_SORTED);
    cmd.rot        = busy_r;
    cmd.new_value  = in_new_value;
    cmd.head_value = head_value;
  end

  slie_array u_array (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .head_value (head_value)
  );

  always_comb begin
    busy_nxt       = busy_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = slie_pkg::ST_ACCEPTED;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b0;

    if (busy_r) begin
      // Streaming: head of the row goes out, the row rotates left by one,
      // so once the final entry is out the list is back in its original order.
      out_valid_nxt  = 1'b1;
      out_status_nxt = slie_pkg::ST_ENTRY;
      out_value_nxt  = head_value;
      out_last_nxt   = read_last;
      idx_nxt        = idx_r + slie_pkg::IDX_W'(1);
      if (read_last) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end else if (accept) begin
      case (in_opcode)
        slie_pkg::OP_APPEND, slie_pkg::OP_SORTED: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_status_nxt = slie_pkg::ST_FULL;
          end else begin
            out_status_nxt = slie_pkg::ST_ACCEPTED;
            count_nxt      = count_r + slie_pkg::CNT_W'(1);
          end
        end
        slie_pkg::OP_READ: begin
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = slie_pkg::ST_EMPTY;
            out_last_nxt   = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end
        default: begin
          // unused opcode: no result, no change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

endmodule

// ----- src/slie_checker.sv -----
// Port-level assertion checker for the sorted list insert engine, with its bind.
`timescale 1ns / 1ps
`include "sorted_list_insert_engine_defines.svh"

module slie_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_opcode,
  input logic                       out_valid,
  input logic [1:0]                 out_status,
  input logic [slie_pkg::VAL_W-1:0] out_entry_value,
  input logic                       out_last
);

  `SLIE_ASSERT_NEXT(a_write_answers, start && !busy && (in_opcode == slie_pkg::OP_APPEND || in_opcode == slie_pkg::OP_SORTED), out_valid && out_last && (out_status == slie_pkg::ST_ACCEPTED || out_status == slie_pkg::ST_FULL), "write command without single answer word")
  `SLIE_ASSERT_NEXT(a_read_starts, start && !busy && in_opcode == slie_pkg::OP_READ, busy || (out_valid && out_last && out_status == slie_pkg::ST_EMPTY), "read-out neither streams nor reports empty")
  `SLIE_ASSERT_NOW(a_value_zero, out_valid && out_status != slie_pkg::ST_ENTRY, out_entry_value == '0 && out_last, "non-entry word with value or without last")
  `SLIE_ASSERT_NOW(a_stream_end, $fell(busy), out_valid && out_last && out_status == slie_pkg::ST_ENTRY, "read-out ended without final entry word")

endmodule

bind sorted_list_insert_engine slie_checker u_slie_checker (.*);
